// ----- sv/qts_pkg.sv -----
// ----------------------------------------------------------------------------
// qts_pkg
// Shared types, widths and constants for the quintic trajectory sampler.
// ----------------------------------------------------------------------------
package qts_pkg;

	localparam int JOINTS_DEF = 7;

	localparam int ANGLE_W = 32;
	localparam int TIME_W  = 64;
	localparam int DUR_W   = 32;
	localparam int JNUM_W  = 3;

	// shared wide multiplier: 32 x 96 in 32-bit chunks
	localparam int MUL_AW     = 32;
	localparam int MUL_BW     = 96;
	localparam int MUL_PW     = 128;
	localparam int MUL_CHUNKS = MUL_BW / MUL_AW;

	// shared divider: 72-bit dividend, 64-bit divisor, 32 quotient bits
	localparam int DIV_NW = 72;
	localparam int DIV_DW = 64;
	localparam int DIV_QW = 32;

	localparam logic [30:0] ONE30   = 31'h4000_0000;
	localparam logic [31:0] MILLION = 32'd1000000;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic [1:0] CFG_MODE     = 2'd0;
	localparam logic [1:0] CFG_START    = 2'd1;
	localparam logic [1:0] CFG_DURATION = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_TIME,
		ST_DIVU,
		ST_U2,
		ST_U3,
		ST_S,
		ST_W,
		ST_SV,
		ST_SA,
		ST_KV,
		ST_KA1,
		ST_KA2,
		ST_DD,
		ST_RD,
		ST_DIST,
		ST_PM,
		ST_VM,
		ST_VD,
		ST_AM,
		ST_AD,
		ST_EMIT
	} qts_state_t;

	// clip a Q15.16 magnitude and apply its sign
	function automatic logic [31:0] sat_q16(input logic [31:0] quo, input logic ovf,
			input logic neg);
		logic [32:0] mag;
		logic [32:0] lim;
		mag = ovf ? 33'h1_0000_0000 : {1'b0, quo};
		if (neg) begin
			lim = (mag > 33'h0_8000_0000) ? 33'h0_8000_0000 : mag;
			return 32'(33'd0 - lim);
		end
		lim = (mag > 33'h0_7FFF_FFFF) ? 33'h0_7FFF_FFFF : mag;
		return lim[31:0];
	endfunction

endpackage

// ----- sv/quintic_trajectory_sampler.sv -----
// ----------------------------------------------------------------------------
// quintic_trajectory_sampler
// Multi-joint quintic time-scaling trajectory sampler over a joint table RAM.
// ----------------------------------------------------------------------------
// Usage: configuration words (mode, start time, duration) go in on the cfg
// channel while the block is idle. Input words on s_axis either load one
// joint's start/target angles into the joint RAM (tuser = 0, no output) or
// request a sample at a timestamp (tuser = 1). A sample gives one output word
// per joint on m_axis, joint 0 first, tlast on the final joint.
// Sequencing: a load only writes the joint RAM and leaves the sequencer idle.
// A sample mid-move in quintic mode runs the time check and the shared scalars
// (one division for u, ten multiplies), then per joint a RAM read, the distance,
// three multiplies (position, velocity, acceleration) and two divisions on the
// shared divider (velocity, acceleration). Before start, after the end or in
// endpoint mode the scalars and the velocity and acceleration steps are skipped
// and a joint runs only its read, distance, position multiply and emit steps.
// s_axis_tready is high only while the sequencer is idle. A stalled m_axis
// holds the sequencer in its emit step; the last result may wait in the
// output register while the next input word is already accepted.
// Reset: mode quintic, start time 0, duration 1 us; joint RAM contents are
// undefined until loaded. No clearing pass is run.
// ----------------------------------------------------------------------------
module quintic_trajectory_sampler #(
	parameter int JOINTS = qts_pkg::JOINTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// cfg: index 0 motion mode, 1 move start time, 2 move duration
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// joint_select[2:0], start_angle[34:3], target_angle[66:35],
	// sample_time_us[130:67], zero fill above
	input  logic [135:0] s_axis_tdata,
	// operation
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// joint_number[2:0], position_out[34:3], velocity_out[66:35],
	// acceleration_out[98:67], zero fill above
	output logic [103:0] m_axis_tdata,
	// move_complete
	output logic         m_axis_tuser,
	// last_joint
	output logic         m_axis_tlast
);
	import qts_pkg::*;

	localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

	qts_state_t state_q, state_d;

	// configuration
	logic              mode_q;
	logic [TIME_W-1:0] tstart_q;
	logic [DUR_W-1:0]  dur_q;

	// input word fields
	logic                in_fire;
	logic [JNUM_W-1:0]   in_sel;
	logic [ANGLE_W-1:0]  in_start;
	logic [ANGLE_W-1:0]  in_target;
	logic [TIME_W-1:0]   in_time;

	// sample scalars
	logic [TIME_W-1:0] t_q;
	logic [TIME_W-1:0] e_full;
	logic              in_le;
	logic              in_ge;
	logic [31:0]       e_q;
	logic [31:0]       u_q;
	logic [31:0]       u2_q;
	logic [31:0]       u3_q;
	logic [31:0]       w_q;
	logic [30:0]       s30_q;
	logic [32:0]       sv_q;
	logic [35:0]       sa_q;
	logic              sa_neg_q;
	logic [52:0]       kv_q;
	logic [75:0]       ka_q;
	logic [63:0]       dd_q;
	logic              complete_q;
	logic              skip_q;
	logic [35:0]       poly;
	logic [32:0]       twou;
	logic              twou_gt;
	logic [31:0]       wbig;
	logic [31:0]       v_u;
	logic [33:0]       s34;
	logic [31:0]       hi32;

	// per-joint values
	logic [JW-1:0]       j_q;
	logic                j_last;
	logic [ANGLE_W-1:0]  st_q;
	logic [31:0]         ad_q;
	logic                neg_q;
	logic [ANGLE_W-1:0]  pos_q;
	logic [31:0]         vel_q;
	logic [31:0]         acc_q;
	logic [DIV_NW-1:0]   n_q;
	logic [32:0]         delta;
	logic [31:0]         pm;

	// shared units
	logic                issued_q;
	logic                mul_start;
	logic [MUL_AW-1:0]   mul_a;
	logic [MUL_BW-1:0]   mul_b;
	logic [MUL_PW-1:0]   mul_prod;
	logic                mul_done;
	logic                div_start;
	logic [DIV_NW-1:0]   div_num;
	logic [DIV_DW-1:0]   div_den;
	logic [DIV_QW-1:0]   div_quo;
	logic                div_ovf;
	logic                div_done;

	// joint RAM
	logic                   ram_we;
	logic                   ram_re;
	logic [2*ANGLE_W-1:0]   ram_rdata;

	// output register
	logic                emit_go;
	logic                out_valid_q;
	logic [JNUM_W-1:0]   out_joint_q;
	logic [ANGLE_W-1:0]  out_pos_q;
	logic [31:0]         out_vel_q;
	logic [31:0]         out_acc_q;
	logic                out_cmp_q;
	logic                out_last_q;

	assign in_sel    = s_axis_tdata[2:0];
	assign in_start  = s_axis_tdata[34:3];
	assign in_target = s_axis_tdata[66:35];
	assign in_time   = s_axis_tdata[130:67];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b1;
			tstart_q <= '0;
			dur_q    <= 32'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MODE: begin
					mode_q <= cfg_data[0];
				end
				CFG_START: begin
					tstart_q <= cfg_data;
				end
				CFG_DURATION: begin
					// a zero duration is taken as one microsecond
					dur_q <= (cfg_data[31:0] == 32'd0) ? 32'd1 : cfg_data[31:0];
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------- joint RAM
	// Loads only write while idle and samples only read while busy, so the
	// two ports never touch the same entry in one cycle.
	assign ram_we = in_fire && (s_axis_tuser == OP_LOAD) && (int'(in_sel) < JOINTS);
	assign ram_re = (state_q == ST_RD);

	qts_ram #(
		.WIDTH (2*ANGLE_W),
		.DEPTH (JOINTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (JW'(in_sel)),
		.wdata ({in_target, in_start}),
		.re    (ram_re),
		.raddr (j_q),
		.rdata (ram_rdata)
	);

	// --------------------------------------------------------- shared units
	qts_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.prod   (mul_prod),
		.done   (mul_done)
	);

	qts_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.ovf    (div_ovf),
		.done   (div_done)
	);

	// ------------------------------------------------------ combinational
	always_comb begin
		e_full  = t_q - tstart_q;
		in_le   = t_q <= tstart_q;
		in_ge   = e_full >= TIME_W'(dur_q);
		// p = 6*u^2 + 10 - 15*u in Q4.32
		poly    = ({4'b0, u2_q} << 2) + ({4'b0, u2_q} << 1) + (36'd10 << 32)
			- (({4'b0, u_q} << 4) - {4'b0, u_q});
		v_u     = 32'(33'h1_0000_0000 - {1'b0, u_q});
		twou    = {u_q, 1'b0};
		twou_gt = twou > 33'h1_0000_0000;
		wbig    = twou_gt ? 32'(twou - 33'h1_0000_0000) : 32'(33'h1_0000_0000 - twou);
		s34     = mul_prod[63:30];
		hi32    = mul_prod[63:32];
		pm      = mul_prod[61:30];
		delta   = {ram_rdata[63], ram_rdata[63:32]} - {ram_rdata[31], ram_rdata[31:0]};
		j_last  = (j_q == JW'(JOINTS - 1));
	end

	// ------------------------------------------------------------ sequencer
	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		div_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_num   = '0;
		div_den   = '0;
		emit_go   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && (s_axis_tuser == OP_SAMPLE)) begin
					state_d = ST_TIME;
				end
			end
			ST_TIME: begin
				state_d = (!mode_q || in_le || in_ge) ? ST_RD : ST_DIVU;
			end
			ST_DIVU: begin
				div_num   = DIV_NW'({e_q, 32'h0});
				div_den   = DIV_DW'(dur_q);
				div_start = !issued_q;
				if (div_done) begin
					state_d = ST_U2;
				end
			end
			ST_U2: begin
				mul_a     = u_q;
				mul_b     = MUL_BW'(u_q);
				mul_start = !issued_q;
				if (mul_done) begin
					state_d = ST_U3;
				end
			end
			ST_U3: begin
				mul_a     = u2_q;
				mul_b     = MUL_BW'(u_q);
				mul_start = !issued_q;
				if (mul_done) begin
					state_d = ST_S;
				end
			end
			ST_S: begin
				mul_a     = u3_q;
				mul_b     = MUL_BW'(poly[35:4]);
				mul_start = !issued_q;
				if (mul_done) begin
					state_d = ST_W;
				end
			end
			ST_W: begin
				mul_a     = u_q;
				mul_b     = MUL_BW'(v_u);
				mul_start = !issued_q;
				if (mul_done) begin
					state_d = ST_SV;
				end
			end
			ST_SV: begin
				mul_a     = w_q;
				mul_b     = MUL_BW'(w_q);
				mul_start = !issued_q;
				if (mul_done) begin
					state_d = ST_SA;
				end
			end
			ST_SA: begin
				mul_a     = w_q;
				mul_b     = MUL_BW'(wbig);
				mul_start = !issued_q;
				if (mul_done) begin
					state_d = ST_KV;
				end
			end
			ST_KV: begin
				mul_a     = MILLION;
				mul_b     = MUL_BW'(sv_q);
				mul_start = !issued_q;
				if (mul_done) begin
					state_d = ST_KA1;
				end
			end
			ST_KA1: begin
				mul_a     = MILLION;
				mul_b     = MUL_BW'(sa_q);
				mul_start = !issued_q;
				if (mul_done) begin
					state_d = ST_KA2;
				end
			end
			ST_KA2: begin
				mul_a     = MILLION;
				mul_b     = MUL_BW'(ka_q);
				mul_start = !issued_q;
				if (mul_done) begin
					state_d = ST_DD;
				end
			end
			ST_DD: begin
				mul_a     = dur_q;
				mul_b     = MUL_BW'(dur_q);
				mul_start = !issued_q;
				if (mul_done) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				state_d = ST_DIST;
			end
			ST_DIST: begin
				state_d = ST_PM;
			end
			ST_PM: begin
				mul_a     = ad_q;
				mul_b     = MUL_BW'(s30_q);
				mul_start = !issued_q;
				if (mul_done) begin
					state_d = skip_q ? ST_EMIT : ST_VM;
				end
			end
			ST_VM: begin
				mul_a     = ad_q;
				mul_b     = MUL_BW'(kv_q);
				mul_start = !issued_q;
				if (mul_done) begin
					state_d = ST_VD;
				end
			end
			ST_VD: begin
				div_num   = n_q;
				div_den   = DIV_DW'(dur_q);
				div_start = !issued_q;
				if (div_done) begin
					state_d = ST_AM;
				end
			end
			ST_AM: begin
				mul_a     = ad_q;
				mul_b     = MUL_BW'(ka_q);
				mul_start = !issued_q;
				if (mul_done) begin
					state_d = ST_AD;
				end
			end
			ST_AD: begin
				div_num   = n_q;
				div_den   = dd_q;
				div_start = !issued_q;
				if (div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				// advance only when the output register is free
				emit_go = !out_valid_q || m_axis_tready;
				if (emit_go) begin
					state_d = j_last ? ST_IDLE : ST_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issued_q    <= 1'b0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			// one operation in flight on the shared units at a time
			issued_q <= (issued_q || mul_start || div_start) && !(mul_done || div_done);
			if (state_q == ST_TIME) begin
				j_q <= '0;
			end else if (emit_go) begin
				j_q <= j_q + JW'(1);
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// -------------------------------------------------------------- datapath
	always_ff @(posedge clk) begin
		if (in_fire) begin
			t_q <= in_time;
		end
		if (state_q == ST_TIME) begin
			complete_q <= !in_le && in_ge;
			e_q        <= e_full[31:0];
			sa_neg_q   <= 1'b0;
			priority if (!mode_q) begin
				s30_q  <= ONE30;
				skip_q <= 1'b1;
			end else if (in_le) begin
				s30_q  <= '0;
				skip_q <= 1'b1;
			end else if (in_ge) begin
				s30_q  <= ONE30;
				skip_q <= 1'b1;
			end else begin
				skip_q <= 1'b0;
			end
		end
		if (div_done) begin
			unique case (state_q)
				ST_DIVU: begin
					u_q <= div_quo;
				end
				ST_VD: begin
					vel_q <= sat_q16(div_quo, div_ovf, neg_q);
				end
				ST_AD: begin
					acc_q <= sat_q16(div_quo, div_ovf, neg_q ^ sa_neg_q);
				end
				default: begin
				end
			endcase
		end
		if (mul_done) begin
			unique case (state_q)
				ST_U2: begin
					u2_q <= hi32;
				end
				ST_U3: begin
					u3_q <= hi32;
				end
				ST_S: begin
					s30_q <= (s34 > 34'(ONE30)) ? ONE30 : s34[30:0];
				end
				ST_W: begin
					w_q <= hi32;
				end
				ST_SV: begin
					sv_q <= 33'({hi32, 5'b0} - {hi32, 1'b0});
				end
				ST_SA: begin
					sa_q     <= 36'({hi32, 6'b0} - {hi32, 2'b0});
					sa_neg_q <= twou_gt;
				end
				ST_KV: begin
					kv_q <= mul_prod[52:0];
				end
				ST_KA1, ST_KA2: begin
					ka_q <= mul_prod[75:0];
				end
				ST_DD: begin
					dd_q <= mul_prod[63:0];
				end
				ST_PM: begin
					pos_q <= neg_q ? (st_q - pm) : (st_q + pm);
					vel_q <= '0;
					acc_q <= '0;
				end
				ST_VM, ST_AM: begin
					// drop the 2^-43 scale before dividing
					n_q <= mul_prod[DIV_NW+42:43];
				end
				default: begin
				end
			endcase
		end
		if (state_q == ST_DIST) begin
			st_q  <= ram_rdata[31:0];
			neg_q <= delta[32];
			ad_q  <= delta[32] ? 32'(33'd0 - delta) : delta[31:0];
		end
		if (emit_go) begin
			out_joint_q <= JNUM_W'(j_q);
			out_pos_q   <= pos_q;
			out_vel_q   <= vel_q;
			out_acc_q   <= acc_q;
			out_cmp_q   <= complete_q;
			out_last_q  <= j_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_acc_q, out_vel_q, out_pos_q, out_joint_q};
	assign m_axis_tuser  = out_cmp_q;
	assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
	ap_sample_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (s_axis_tuser == OP_SAMPLE)) |=> (state_q == ST_TIME))
		else $error("sample word did not start the sequencer");

	ap_done_issued: assert property (@(posedge clk) disable iff (!arst_n)
		(mul_done || div_done) |-> issued_q)
		else $error("arithmetic unit finished without an issued operation");

	ap_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && j_last) |=> (state_q == ST_IDLE && m_axis_tvalid && m_axis_tlast))
		else $error("final joint did not close the sample");

	ap_tlast_joint: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (out_joint_q == JNUM_W'(JOINTS - 1)))
		else $error("tlast on a joint other than the final one");
`endif

endmodule

// ----- sv/qts_ram.sv -----
// ----------------------------------------------------------------------------
// qts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module qts_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 7,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/qts_mul.sv -----
// ----------------------------------------------------------------------------
// qts_mul
// Sequential 32 x 96 multiplier, one 32 x 32 partial product per cycle.
// ----------------------------------------------------------------------------
module qts_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [qts_pkg::MUL_AW-1:0]   a,
	input  logic [qts_pkg::MUL_BW-1:0]   b,
	output logic [qts_pkg::MUL_PW-1:0]   prod,
	output logic                         done
);
	import qts_pkg::*;

	logic [MUL_AW-1:0]   a_q;
	logic [MUL_BW-1:0]   b_q;
	logic [MUL_PW-1:0]   acc_q;
	logic [1:0]          cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [MUL_AW-1:0]   chunk;
	logic [2*MUL_AW-1:0] part;
	logic [MUL_PW-1:0]   part_sh;

	always_comb begin
		chunk   = b_q[cnt_q*MUL_AW +: MUL_AW];
		part    = a_q * chunk;
		part_sh = MUL_PW'(part) << (cnt_q * MUL_AW);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'(MUL_CHUNKS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + part_sh;
		end
	end

	assign prod = acc_q;
	assign done = done_q;

endmodule

// ----- sv/qts_div.sv -----
// ----------------------------------------------------------------------------
// qts_div
// Restoring divider, one quotient bit per cycle, with quotient overflow flag.
// ----------------------------------------------------------------------------
module qts_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [qts_pkg::DIV_NW-1:0]  num,
	input  logic [qts_pkg::DIV_DW-1:0]  den,
	output logic [qts_pkg::DIV_QW-1:0]  quo,
	output logic                        ovf,
	output logic                        done
);
	import qts_pkg::*;

	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_QW-1:0] low_q;
	logic [DIV_QW-1:0] quo_q;
	logic              ovf_q;
	logic [4:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   trial;
	logic              fits;

	always_comb begin
		trial = {rem_q, low_q[DIV_QW-1]};
		fits  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(DIV_QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// quotient would not fit in DIV_QW bits
			ovf_q <= DIV_DW'(num[DIV_NW-1:DIV_QW]) >= den;
			rem_q <= DIV_DW'(num[DIV_NW-1:DIV_QW]);
			low_q <= num[DIV_QW-1:0];
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
			low_q <= {low_q[DIV_QW-2:0], 1'b0};
			quo_q <= {quo_q[DIV_QW-2:0], fits};
		end
	end

	assign quo  = quo_q;
	assign ovf  = ovf_q;
	assign done = done_q;

endmodule
